FILE: rtl/smrs_pkg.sv
// Package for the sorted multiset rank/select block.
// Holds sizing constants, command and status codes and the sequencer state type.
// No dependencies.
package smrs_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 7;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_EXISTS = 3'd2,
        CMD_RANK   = 3'd3,
        CMD_SELECT = 3'd4,
        CMD_PRED   = 3'd5,
        CMD_SUCC   = 3'd6,
        CMD_CLEAR  = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NOTFOUND = 2'd1,
        STS_FULL     = 2'd2,
        STS_RANGE    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SEARCH_CMP,
        S_POST,
        S_FETCH,
        S_UP_RD,
        S_UP_WR,
        S_PUT,
        S_DN_RD,
        S_DN_WR,
        S_RESP
    } t_state;

endpackage

FILE: rtl/smrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module smrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/sorted_multiset_rank_select.sv
// Sorted multiset of signed 32-bit values with rank and select queries.
// Depends on smrs_pkg and smrs_ram.
//
// Usage:
//   Input channel: i_in_valid / o_in_ready carry one command beat (i_cmd,
//   i_operand_value). Output channel: o_out_valid / i_out_ready carry one
//   result beat (o_answer, o_status, o_occupancy) for every command beat.
//   One command is processed at a time; o_in_ready is high only while the
//   sequencer is idle, and a new command may be taken while the previous
//   result still waits in the output register.
//   A binary search step reads through the single RAM read port in S_SEARCH
//   and compares with one comparator in S_SEARCH_CMP. Insert and delete
//   then move the tail one entry at a time, each in a read state and then
//   a write state (S_UP_RD/S_UP_WR, S_DN_RD/S_DN_WR).
//   Reset empties the store (count to zero) and drops any pending result;
//   the RAM contents are not cleared. While i_out_ready is low a finished
//   result holds and the sequencer waits before writing the next one.
module sorted_multiset_rank_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic signed [31:0] i_operand_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_answer,
    output logic [1:0]  o_status,
    output logic [6:0]  o_occupancy
);

    smrs_pkg::t_state  r_state, n_state;
    smrs_pkg::t_cmd    r_cmd, n_cmd;
    logic signed [smrs_pkg::DATA_W-1:0] r_val, n_val;
    logic [smrs_pkg::CNT_W-1:0] r_lo, n_lo;
    logic [smrs_pkg::CNT_W-1:0] r_hi, n_hi;
    logic [smrs_pkg::CNT_W-1:0] r_idx, n_idx;
    logic [smrs_pkg::CNT_W-1:0] r_count, n_count;
    logic [smrs_pkg::DATA_W-1:0] r_answer, n_answer;
    smrs_pkg::t_status r_status, n_status;
    logic        r_out_valid, n_out_valid;
    logic [smrs_pkg::DATA_W-1:0] r_o_answer, n_o_answer;
    logic [1:0]  r_o_status, n_o_status;
    logic [smrs_pkg::OCC_W-1:0] r_o_occ, n_o_occ;

    logic                        w_wr_en;
    logic [smrs_pkg::IDX_W-1:0]  w_wr_addr;
    logic [smrs_pkg::DATA_W-1:0] w_wr_data;
    logic [smrs_pkg::IDX_W-1:0]  w_rd_addr;
    logic [smrs_pkg::DATA_W-1:0] w_rd_data;

    logic                        w_lt;
    logic                        w_eq;
    logic [smrs_pkg::CNT_W:0]    w_sum;
    logic [smrs_pkg::CNT_W-1:0]  w_mid;
    logic [smrs_pkg::CNT_W:0]    w_idx_inc;
    logic [smrs_pkg::DATA_W-1:0] w_sel_m1;
    logic                        w_sel_ok;

    smrs_ram #(
        .WIDTH (smrs_pkg::DATA_W),
        .DEPTH (smrs_pkg::CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_lt      = $signed(w_rd_data) < r_val;
    assign w_eq      = w_rd_data == r_val;
    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_sum[smrs_pkg::CNT_W:1];
    assign w_idx_inc = {1'b0, r_idx} + (smrs_pkg::CNT_W+1)'(1);
    assign w_sel_m1  = r_val - smrs_pkg::DATA_W'(1);
    assign w_sel_ok  = (r_val > 0) &&
                       ($unsigned(r_val) <= smrs_pkg::DATA_W'(r_count));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smrs_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_val      <= n_val;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_idx      <= n_idx;
        r_answer   <= n_answer;
        r_status   <= n_status;
        r_o_answer <= n_o_answer;
        r_o_status <= n_o_status;
        r_o_occ    <= n_o_occ;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_idx       = r_idx;
        n_count     = r_count;
        n_answer    = r_answer;
        n_status    = r_status;
        n_o_answer  = r_o_answer;
        n_o_status  = r_o_status;
        n_o_occ     = r_o_occ;
        n_out_valid = r_out_valid && !i_out_ready;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx[smrs_pkg::IDX_W-1:0];
        w_wr_data   = w_rd_data;
        w_rd_addr   = '0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            smrs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_cmd   = smrs_pkg::t_cmd'(i_cmd);
                    n_val   = i_operand_value;
                    n_state = smrs_pkg::S_DISPATCH;
                end
            end
            smrs_pkg::S_DISPATCH: begin
                n_answer = '0;
                n_status = smrs_pkg::STS_OK;
                n_lo     = '0;
                n_hi     = r_count;
                n_state  = smrs_pkg::S_SEARCH;
                unique case (r_cmd)
                    smrs_pkg::CMD_INSERT: begin
                        if (r_count >= smrs_pkg::CNT_W'(smrs_pkg::CAPACITY)) begin
                            n_status = smrs_pkg::STS_FULL;
                            n_state  = smrs_pkg::S_RESP;
                        end
                    end
                    smrs_pkg::CMD_SELECT: begin
                        if (w_sel_ok) begin
                            w_rd_addr = w_sel_m1[smrs_pkg::IDX_W-1:0];
                            n_state   = smrs_pkg::S_FETCH;
                        end else begin
                            n_status = smrs_pkg::STS_RANGE;
                            n_state  = smrs_pkg::S_RESP;
                        end
                    end
                    smrs_pkg::CMD_CLEAR: begin
                        n_count = '0;
                        n_state = smrs_pkg::S_RESP;
                    end
                    smrs_pkg::CMD_DELETE, smrs_pkg::CMD_EXISTS, smrs_pkg::CMD_RANK,
                    smrs_pkg::CMD_PRED, smrs_pkg::CMD_SUCC: begin
                        n_state = smrs_pkg::S_SEARCH;
                    end
                endcase
            end
            smrs_pkg::S_SEARCH: begin
                if (r_lo < r_hi) begin
                    w_rd_addr = w_mid[smrs_pkg::IDX_W-1:0];
                    n_idx     = w_mid;
                    n_state   = smrs_pkg::S_SEARCH_CMP;
                end else begin
                    n_state = smrs_pkg::S_POST;
                end
            end
            smrs_pkg::S_SEARCH_CMP: begin
                if (w_lt || (w_eq && (r_cmd == smrs_pkg::CMD_SUCC))) begin
                    n_lo = w_idx_inc[smrs_pkg::CNT_W-1:0];
                end else begin
                    n_hi = r_idx;
                end
                n_state = smrs_pkg::S_SEARCH;
            end
            smrs_pkg::S_POST: begin
                n_state = smrs_pkg::S_RESP;
                unique case (r_cmd)
                    smrs_pkg::CMD_INSERT: begin
                        n_idx   = r_count;
                        n_state = smrs_pkg::S_UP_RD;
                    end
                    smrs_pkg::CMD_DELETE, smrs_pkg::CMD_EXISTS, smrs_pkg::CMD_SUCC: begin
                        if (r_lo < r_count) begin
                            w_rd_addr = r_lo[smrs_pkg::IDX_W-1:0];
                            n_state   = smrs_pkg::S_FETCH;
                        end else if (r_cmd != smrs_pkg::CMD_EXISTS) begin
                            n_status = smrs_pkg::STS_NOTFOUND;
                        end
                    end
                    smrs_pkg::CMD_RANK: begin
                        n_answer = smrs_pkg::DATA_W'(r_lo) + smrs_pkg::DATA_W'(1);
                    end
                    smrs_pkg::CMD_PRED: begin
                        if (r_lo == '0) begin
                            n_status = smrs_pkg::STS_NOTFOUND;
                        end else begin
                            w_rd_addr = smrs_pkg::IDX_W'(r_lo - smrs_pkg::CNT_W'(1));
                            n_state   = smrs_pkg::S_FETCH;
                        end
                    end
                    smrs_pkg::CMD_SELECT, smrs_pkg::CMD_CLEAR: begin
                        n_state = smrs_pkg::S_RESP;
                    end
                endcase
            end
            smrs_pkg::S_FETCH: begin
                n_state = smrs_pkg::S_RESP;
                unique case (r_cmd)
                    smrs_pkg::CMD_EXISTS: begin
                        n_answer = w_eq ? smrs_pkg::DATA_W'(1) : '0;
                    end
                    smrs_pkg::CMD_DELETE: begin
                        if (w_eq) begin
                            n_idx   = r_lo;
                            n_state = smrs_pkg::S_DN_RD;
                        end else begin
                            n_status = smrs_pkg::STS_NOTFOUND;
                        end
                    end
                    smrs_pkg::CMD_SELECT, smrs_pkg::CMD_PRED, smrs_pkg::CMD_SUCC: begin
                        n_answer = w_rd_data;
                    end
                    smrs_pkg::CMD_INSERT, smrs_pkg::CMD_RANK, smrs_pkg::CMD_CLEAR: begin
                        n_state = smrs_pkg::S_RESP;
                    end
                endcase
            end
            smrs_pkg::S_UP_RD: begin
                if (r_idx > r_lo) begin
                    w_rd_addr = smrs_pkg::IDX_W'(r_idx - smrs_pkg::CNT_W'(1));
                    n_state   = smrs_pkg::S_UP_WR;
                end else begin
                    n_state = smrs_pkg::S_PUT;
                end
            end
            smrs_pkg::S_UP_WR: begin
                w_wr_en = 1'b1;
                n_idx   = r_idx - smrs_pkg::CNT_W'(1);
                n_state = smrs_pkg::S_UP_RD;
            end
            smrs_pkg::S_PUT: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_lo[smrs_pkg::IDX_W-1:0];
                w_wr_data = r_val;
                n_count   = r_count + smrs_pkg::CNT_W'(1);
                n_state   = smrs_pkg::S_RESP;
            end
            smrs_pkg::S_DN_RD: begin
                if (w_idx_inc < {1'b0, r_count}) begin
                    w_rd_addr = w_idx_inc[smrs_pkg::IDX_W-1:0];
                    n_state   = smrs_pkg::S_DN_WR;
                end else begin
                    n_count = r_count - smrs_pkg::CNT_W'(1);
                    n_state = smrs_pkg::S_RESP;
                end
            end
            smrs_pkg::S_DN_WR: begin
                w_wr_en = 1'b1;
                n_idx   = w_idx_inc[smrs_pkg::CNT_W-1:0];
                n_state = smrs_pkg::S_DN_RD;
            end
            smrs_pkg::S_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_o_answer  = r_answer;
                    n_o_status  = r_status;
                    n_o_occ     = smrs_pkg::OCC_W'(r_count);
                    n_out_valid = 1'b1;
                    n_state     = smrs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = smrs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_answer    = r_o_answer;
    assign o_status    = r_o_status;
    assign o_occupancy = r_o_occ;

endmodule

FILE: rtl/smrs_chk.sv
// Port-level checker for the sorted multiset rank/select block, bound to the top level.
// Depends on smrs_pkg.
module smrs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic signed [31:0] o_answer,
    input logic [1:0]  o_status,
    input logic [6:0]  o_occupancy
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat pending after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_answer) && $stable(o_status) && $stable(o_occupancy))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("command taken while previous command in flight");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == smrs_pkg::STS_FULL) |->
            o_occupancy == smrs_pkg::OCC_W'(smrs_pkg::CAPACITY))
        else $error("full status with store not full");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != smrs_pkg::STS_OK) |-> o_answer == '0)
        else $error("non-zero answer on failed command");

endmodule

bind sorted_multiset_rank_select smrs_chk u_smrs_chk (.*);
